// ===== sv/qdp_pkg.sv =====
// Shared types and constants for the quadrature decoder with period average.
// Used by qdp_front, qdp_queue, qdp_back and the top level.
package qdp_pkg;

    // Result status codes
    localparam logic [1:0] ST_COUNTED  = 2'd0;
    localparam logic [1:0] ST_LEARNING = 2'd1;
    localparam logic [1:0] ST_IGNORED  = 2'd2;

    // Direction codes (signed two-bit step)
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_FWD  = 2'b01;
    localparam logic [1:0] DIR_REV  = 2'b11;

    // Field widths
    localparam int TS_W  = 64;
    localparam int POS_W = 32;

    // Averaging window; must be a power of two so the divide is a shift
    localparam int AVG_SHIFT = 3;
    localparam int AVG_LEN   = 1 << AVG_SHIFT;
    // Width that holds avg * (AVG_LEN - 1) + interval without overflow
    localparam int BLEND_W   = TS_W + AVG_SHIFT + 1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified event handed from front to back
    typedef struct packed {
        logic [1:0]      status;
        logic            step_up;
        logic            do_avg;
        logic [TS_W-1:0] ts;
        logic [TS_W-1:0] interval;
    } qdp_item_t;

endpackage

// ===== sv/qdp_front.sv =====
// Front end: accepts edge transactions, tracks line levels, classifies events
// and forms the A-rise interval. Depends on qdp_pkg.
module qdp_front
    import qdp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            channel,
    input  logic            rising,
    input  logic [TS_W-1:0] timestamp,
    output qdp_item_t       item
);

    logic            a_known_reg, a_known_next;
    logic            b_known_reg, b_known_next;
    logic            level_a_reg, level_a_next;
    logic            level_b_reg, level_b_next;
    logic            rise_seen_reg, rise_seen_next;
    logic [TS_W-1:0] rise_time_reg, rise_time_next;

    // Classification and level tracking
    always_comb
    begin
        a_known_next   = a_known_reg;
        b_known_next   = b_known_reg;
        level_a_next   = level_a_reg;
        level_b_next   = level_b_reg;
        rise_seen_next = rise_seen_reg;
        rise_time_next = rise_time_reg;

        item.status   = ST_COUNTED;
        item.step_up  = 1'b0;
        item.do_avg   = 1'b0;
        item.ts       = timestamp;
        item.interval = timestamp - rise_time_reg;

        if (!(a_known_reg && b_known_reg))
        begin
            // still learning the line levels
            item.status = ST_LEARNING;
            if (channel)
            begin
                level_b_next = rising;
                b_known_next = 1'b1;
            end
            else
            begin
                level_a_next = rising;
                a_known_next = 1'b1;
            end
        end
        else if (channel ? (level_b_reg == rising) : (level_a_reg == rising))
        begin
            // edge to the level already held
            item.status = ST_IGNORED;
        end
        else
        begin
            if (channel)
            begin
                level_b_next = rising;
                item.step_up = (rising == level_a_reg);
            end
            else
            begin
                level_a_next = rising;
                item.step_up = (rising != level_b_reg);
                if (rising)
                begin
                    item.do_avg    = rise_seen_reg;
                    rise_seen_next = 1'b1;
                    rise_time_next = timestamp;
                end
            end
        end
    end

    // State update on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_known_reg   <= 1'b0;
            b_known_reg   <= 1'b0;
            level_a_reg   <= 1'b0;
            level_b_reg   <= 1'b0;
            rise_seen_reg <= 1'b0;
            rise_time_reg <= '0;
        end
        else if (accept)
        begin
            a_known_reg   <= a_known_next;
            b_known_reg   <= b_known_next;
            level_a_reg   <= level_a_next;
            level_b_reg   <= level_b_next;
            rise_seen_reg <= rise_seen_next;
            rise_time_reg <= rise_time_next;
        end
    end

endmodule

// ===== sv/qdp_queue.sv =====
// Short register queue carrying classified events from front to back.
// Depends on qdp_pkg.
module qdp_queue
    import qdp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  qdp_item_t push_item,
    output logic      full,
    input  logic      pop,
    output qdp_item_t pop_item,
    output logic      empty
);

    qdp_item_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/qdp_back.sv =====
// Back end: applies counted events to position, direction, time and the
// running period average, and holds the result register. Depends on qdp_pkg.
module qdp_back
    import qdp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  qdp_item_t        item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       status,
    output logic [POS_W-1:0] position,
    output logic [1:0]       direction,
    output logic [TS_W-1:0]  period_average,
    output logic [TS_W-1:0]  last_count_time
);

    logic [POS_W-1:0]   count_reg, count_next;
    logic [1:0]         step_reg, step_next;
    logic [TS_W-1:0]    ctime_reg, ctime_next;
    logic [TS_W-1:0]    avg_reg, avg_next;
    logic [BLEND_W-1:0] blend_sum;
    logic               valid_reg;
    logic [1:0]         status_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [1:0]         dir_reg;
    logic [TS_W-1:0]    pavg_reg;
    logic [TS_W-1:0]    ltime_reg;

    // Take the next event whenever the result register is free or draining
    assign pop = !empty && (!valid_reg || !out_stall);

    // avg * (AVG_LEN - 1) + interval, then divide by AVG_LEN
    assign blend_sum = (BLEND_W'(avg_reg) << AVG_SHIFT) - BLEND_W'(avg_reg)
                     + BLEND_W'(item.interval);

    // Event execution
    always_comb
    begin
        count_next = count_reg;
        step_next  = step_reg;
        ctime_next = ctime_reg;
        avg_next   = avg_reg;
        if (item.status == ST_COUNTED)
        begin
            step_next  = item.step_up ? DIR_FWD : DIR_REV;
            count_next = item.step_up ? count_reg + 1'b1 : count_reg - 1'b1;
            ctime_next = item.ts;
            if (item.do_avg)
            begin
                avg_next = (avg_reg == '0) ? item.interval
                                           : blend_sum[AVG_SHIFT +: TS_W];
            end
        end
    end

    // Held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            step_reg  <= DIR_NONE;
            ctime_reg <= '0;
            avg_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                count_reg <= count_next;
                step_reg  <= step_next;
                ctime_reg <= ctime_next;
                avg_reg   <= avg_next;
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= item.status;
            pos_reg    <= count_next;
            dir_reg    <= step_next;
            pavg_reg   <= avg_next;
            ltime_reg  <= ctime_next;
        end
    end

    assign out_valid       = valid_reg;
    assign status          = status_reg;
    assign position        = pos_reg;
    assign direction       = dir_reg;
    assign period_average  = pavg_reg;
    assign last_count_time = ltime_reg;

endmodule

// ===== sv/quadrature_decoder_with_period_average.sv =====
// Quadrature x4 decoder with running average of the channel A period.
// Input channel: in_valid / in_stall carrying channel, rising, timestamp; one
// transaction per encoder edge. Output channel: out_valid / out_stall carrying
// status, position, direction, period_average, last_count_time; exactly one
// result transaction per input transaction, in order.
// Throughput: one edge per cycle while in_stall is low. The front classifies an
// edge in the cycle it is accepted; the back updates position and the average
// (shift-and-subtract blend over the window of qdp_pkg::AVG_LEN) for each event it takes.
// Path: an accepted edge is written into the front-to-back queue and then into
// the result register, which raises out_valid; a stalled result or earlier
// queued events keep it waiting in the queue.
// Reset: all levels become unknown, position, direction, time and average go
// to zero, the queue and result register empty.
// Stall: a stalled result holds; the back stops, the two-entry queue fills
// and in_stall rises once it is full, so no transaction is lost.
// Depends on qdp_pkg, qdp_front, qdp_queue, qdp_back.
module quadrature_decoder_with_period_average
    import qdp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    channel,
    input  logic                    rising,
    input  logic [TS_W-1:0]         timestamp,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              status,
    output logic signed [POS_W-1:0] position,
    output logic signed [1:0]       direction,
    output logic [TS_W-1:0]         period_average,
    output logic [TS_W-1:0]         last_count_time
);

    logic      accept;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    qdp_item_t front_item;
    qdp_item_t back_item;
    logic [POS_W-1:0] pos_u;
    logic [1:0]       dir_u;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Edge classification
    qdp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .channel   (channel),
        .rising    (rising),
        .timestamp (timestamp),
        .item      (front_item)
    );

    // Decoupling queue
    qdp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (back_item),
        .empty     (q_empty)
    );

    // Counting, averaging and result register
    qdp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .empty           (q_empty),
        .item            (back_item),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .position        (pos_u),
        .direction       (dir_u),
        .period_average  (period_average),
        .last_count_time (last_count_time)
    );

    assign position  = signed'(pos_u);
    assign direction = signed'(dir_u);

    // A result never carries an unused status code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_COUNTED || status == ST_LEARNING ||
                       status == ST_IGNORED))
        else $error("invalid status code on result");

    // A counted event always leaves a nonzero direction
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_COUNTED) |-> (dir_u != DIR_NONE))
        else $error("counted event without direction");

    // No direction yet means nothing has been counted
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dir_u == DIR_NONE) |-> (pos_u == '0 && last_count_time == '0))
        else $error("position or time moved before any counted event");

    // Learning results only occur before any counting
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_LEARNING) |-> (dir_u == DIR_NONE && period_average == '0))
        else $error("learning result after counting started");

endmodule

// ===== dv/quadrature_decoder_with_period_average_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for quadrature_decoder_with_period_average: drives
// encoder edge transactions and checks each result against a built-in decoder model.
// Depends on qdp_pkg and the quadrature_decoder_with_period_average top level.
module quadrature_decoder_with_period_average_tb;
    import qdp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 60;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP      = 40;
    localparam int WIDE_W       = TS_W + 9;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [POS_W-1:0] position;
        logic signed [1:0]       direction;
        logic [TS_W-1:0]         period_average;
        logic [TS_W-1:0]         last_count_time;
    } edge_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic channel = 1'b0;
    logic rising = 1'b0;
    logic [TS_W-1:0] timestamp = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    logic [1:0] status;
    logic signed [POS_W-1:0] position;
    logic signed [1:0] direction;
    logic [TS_W-1:0] period_average;
    logic [TS_W-1:0] last_count_time;

    // Decoder model state
    logic                    m_a_known = 1'b0;
    logic                    m_b_known = 1'b0;
    logic                    m_level_a = 1'b0;
    logic                    m_level_b = 1'b0;
    logic signed [POS_W-1:0] m_pos = '0;
    logic signed [1:0]       m_dir = DIR_NONE;
    logic [TS_W-1:0]         m_count_ts = '0;
    logic                    m_rise_seen = 1'b0;
    logic [TS_W-1:0]         m_rise_ts = '0;
    logic [TS_W-1:0]         m_avg = '0;

    edge_result_t expected_results[$];
    int mismatches = 0;
    int cycle_count = 0;
    idle_mode_t idle_mode = IDLE_NONE;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    logic [TS_W-1:0] now_ts = '0;

    always #2 clk = ~clk;

    quadrature_decoder_with_period_average u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .channel         (channel),
        .rising          (rising),
        .timestamp       (timestamp),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .position        (position),
        .direction       (direction),
        .period_average  (period_average),
        .last_count_time (last_count_time)
    );

    // Model one accepted edge and queue the result it should produce
    function automatic void track_edge(logic on_b, logic rise, logic [TS_W-1:0] ts);
        logic [1:0]        st;
        logic signed [1:0] step;
        logic [TS_W-1:0]   interval;
        logic [WIDE_W-1:0] acc;
        edge_result_t      r;
        st = ST_COUNTED;
        if (!m_a_known || !m_b_known)
        begin
            // still learning line levels; the completing edge is not counted
            if (on_b)
            begin
                m_level_b = rise;
                m_b_known = 1'b1;
            end
            else
            begin
                m_level_a = rise;
                m_a_known = 1'b1;
            end
            st = ST_LEARNING;
        end
        else if (on_b ? (m_level_b == rise) : (m_level_a == rise))
        begin
            st = ST_IGNORED;
        end
        else
        begin
            if (on_b)
            begin
                m_level_b = rise;
                step = (m_level_b == m_level_a) ? DIR_FWD : DIR_REV;
            end
            else
            begin
                m_level_a = rise;
                step = (m_level_a != m_level_b) ? DIR_FWD : DIR_REV;
            end
            m_dir = step;
            m_pos = (step == DIR_FWD) ? m_pos + 1 : m_pos - 1;
            m_count_ts = ts;
            // period average on counted A rises; first rise only stamps
            if (!on_b && rise)
            begin
                if (m_rise_seen)
                begin
                    interval = ts - m_rise_ts;
                    if (m_avg == '0)
                    begin
                        m_avg = interval;
                    end
                    else
                    begin
                        acc = WIDE_W'(m_avg) * (AVG_LEN - 1) + WIDE_W'(interval);
                        m_avg = TS_W'(acc / AVG_LEN);
                    end
                end
                m_rise_seen = 1'b1;
                m_rise_ts = ts;
            end
        end
        r.status = st;
        r.position = m_pos;
        r.direction = m_dir;
        r.period_average = m_avg;
        r.last_count_time = m_count_ts;
        expected_results.push_back(r);
    endfunction

    // Advance event time by a small random delta
    function automatic logic [TS_W-1:0] tick();
        now_ts = now_ts + TS_W'($urandom_range(1, 3000));
        return now_ts;
    endfunction

    function automatic logic [TS_W-1:0] any_ts();
        return {$urandom, $urandom};
    endfunction

    // Send one edge transaction; valid stays high on return
    task automatic send_edge(logic on_b, logic rise, logic [TS_W-1:0] ts);
        int gap;
        int pct;
        gap = 0;
        pct = (idle_mode == IDLE_SEND) ? 83 : (idle_mode == IDLE_BOTH) ? 31 : 0;
        while (gap < MAX_GAP && $urandom_range(99) < pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        channel <= on_b;
        rising <= rise;
        timestamp <= ts;
        do @(posedge clk); while (in_stall);
        track_edge(on_b, rise, ts);
    endtask

    // One valid Gray-code step in the given direction
    task automatic step_encoder(logic fwd, logic [TS_W-1:0] ts);
        logic toggle_a;
        toggle_a = ((m_level_a == m_level_b) == fwd);
        if (toggle_a)
            send_edge(1'b0, !m_level_a, ts);
        else
            send_edge(1'b1, !m_level_b, ts);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Learning, ignored edges, both directions, wrap below zero, timestamp extremes
    task automatic test_directed();
        int i;
        idle_mode = IDLE_NONE;
        send_edge(1'b0, 1'b1, '0);
        send_edge(1'b0, 1'b0, 64'd5);
        send_edge(1'b1, 1'b1, 64'd10);
        send_edge(1'b1, 1'b1, 64'd12);
        send_edge(1'b0, 1'b0, 64'd20);
        for (i = 0; i < 5; i++)
            step_encoder(1'b0, 64'd100 + 64'(i * 10));
        for (i = 0; i < 8; i++)
            step_encoder(1'b1, 64'd200 + 64'(i * 37));
        // time going backwards
        step_encoder(1'b1, 64'd50);
        // alternate max and zero stamps: huge and tiny intervals, blend near the top
        for (i = 0; i < 6; i++)
            step_encoder(1'b1, (i % 2 == 0) ? {TS_W{1'b1}} : '0);
        wait_drain();
    endtask

    // Mostly valid walks with random direction runs, some noise
    task automatic test_random_phase(idle_mode_t mode, int count);
        int i;
        int pick;
        logic fwd;
        idle_mode = mode;
        fwd = 1'($urandom_range(1));
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(9) == 0)
                fwd = !fwd;
            if (pick < 75)
                step_encoder(fwd, tick());
            else if (pick < 85)
                step_encoder(fwd, any_ts());
            else
                send_edge(1'($urandom_range(1)), 1'($urandom_range(1)), tick());
        end
        wait_drain();
    endtask

    // Receiver holds off while transactions keep coming, so the input stalls
    task automatic test_back_pressure();
        int i;
        idle_mode = IDLE_NONE;
        hold_requests++;
        @(posedge clk);
        for (i = 0; i < 20; i++)
            step_encoder(1'($urandom_range(1)), tick());
        wait_drain();
    endtask

    task automatic check_result(edge_result_t got);
        edge_result_t want;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("ERROR cycle %0d: result with no transaction pending", cycle_count);
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status || got.position !== want.position ||
            got.direction !== want.direction ||
            got.period_average !== want.period_average ||
            got.last_count_time !== want.last_count_time)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("ERROR cycle %0d: result mismatch", cycle_count);
                $display("  exp status=%0d pos=%0d dir=%0d avg=%0d last=%0d", want.status,
                         want.position, want.direction, want.period_average,
                         want.last_count_time);
                $display("  got status=%0d pos=%0d dir=%0d avg=%0d last=%0d", got.status,
                         got.position, got.direction, got.period_average,
                         got.last_count_time);
            end
        end
    endtask

    // Result side: check accepted results, drive random and long stalls
    always @(posedge clk)
    begin
        int pct;
        if (rst_n && out_valid && !out_stall)
            check_result({status, position, direction, period_average, last_count_time});
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        pct = (idle_mode == IDLE_RECV) ? 83 : (idle_mode == IDLE_BOTH) ? 31 : 0;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("quadrature_decoder_with_period_average verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(IDLE_NONE, 140);
        test_back_pressure();
        test_random_phase(IDLE_SEND, 135);
        test_random_phase(IDLE_RECV, 135);
        test_random_phase(IDLE_BOTH, 135);
        wait_drain();
        if (mismatches == 0)
            $display("quadrature_decoder_with_period_average verification clean");
        else
            $display("quadrature_decoder_with_period_average verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/qdp_pkg.sv
sv/qdp_front.sv
sv/qdp_queue.sv
sv/qdp_back.sv
sv/quadrature_decoder_with_period_average.sv
dv/quadrature_decoder_with_period_average_tb.sv
